[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/bss_pkg.sv]
package bss_pkg;

    // Field widths
    localparam int BAUD_W      = 24;
    localparam int REF_W       = 27;
    localparam int SCALE_OUT_W = 8;
    localparam int STEP_OUT_W  = 16;
    localparam int ERR_W       = BAUD_W;

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(25000000);

    // Search limits
    localparam int SCALE_COUNT = 255;
    localparam int STEP_MAX    = 65535;
    localparam int FRAC_SHIFT  = 17;

    // Derived widths
    localparam int SCALE_W    = (SCALE_COUNT > 1) ? $clog2(SCALE_COUNT) : 1;
    localparam int SCALE1_W   = $clog2(SCALE_COUNT + 1);
    localparam int STEP_W     = $clog2(STEP_MAX + 1);
    localparam int BM_W       = BAUD_W + SCALE1_W;
    localparam int NUM_W      = BM_W + FRAC_SHIFT;
    localparam int PROD_W     = REF_W + STEP_W;
    localparam int RATE_NUM_W = PROD_W + 1 - FRAC_SHIFT;
    localparam int CNT_W      = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_MUL,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_CMP,
        ST_FINISH
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   dividend;
        logic [REF_W-1:0]   divisor;
        logic [CNT_W-1:0]   iters;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [NUM_W-1:0]   quotient;
    } div_rsp_t;

endpackage

[src/bss_divider.sv]
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned so that fewer iterations serve a narrower dividend.
module bss_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  bss_pkg::div_req_t  req,
    output bss_pkg::div_rsp_t  rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [bss_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [bss_pkg::REF_W-1:0]     rem_reg, rem_next;
    logic [bss_pkg::NUM_W-1:0]     quo_reg, quo_next;
    logic [bss_pkg::REF_W-1:0]     dsr_reg, dsr_next;

    logic [bss_pkg::REF_W:0]       shifted;
    logic [bss_pkg::REF_W+1:0]     trial;
    logic                          fits;

    // Trial subtract of the shifted partial remainder
    always_comb begin
        shifted = {rem_reg, quo_reg[bss_pkg::NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dsr_reg};
        fits    = !trial[bss_pkg::REF_W+1];
    end

    // Iteration control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial[bss_pkg::REF_W-1:0] : shifted[bss_pkg::REF_W-1:0];
            quo_next = {quo_reg[bss_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg - bss_pkg::CNT_W'(1);
            if (cnt_reg == bss_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[src/baud_scale_step_search.sv]
// Fractional baud divisor search.
// cfg_valid/cfg_ready/cfg_wdata write the reference clock in Hz; cfg_ready is
// always high and a write is meant for when the block is idle.
// s_target_baud is taken on an s_valid/s_ready transfer; s_ready is high only
// while no search is running. One result (m_div_scale, m_div_step,
// m_rate_error) leaves on an m_valid/m_ready transfer for each input.
// Each scale tried runs through the one shared bit-serial divider: the
// step division (start, 49 quotient bits, done), a multiply, the rate
// division (start, 27 quotient bits, done) and a compare.
// A full search tries all 255 scales before m_valid rises; it ends sooner
// once the step exceeds its limit, and a zero reference clock skips the
// divisions and goes straight to the finish state that raises m_valid.
// The result sits in an output register, so a new target is taken while an
// earlier result still waits. If the receiver stalls and the output register
// is full, a finished search holds its result until the slot frees.
// Reset sets the reference clock to 25 MHz and empties the output register.
`include "assert_macros.svh"

module baud_scale_step_search (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bss_pkg::REF_W-1:0]       cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bss_pkg::BAUD_W-1:0]      s_target_baud,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bss_pkg::SCALE_OUT_W-1:0] m_div_scale,
    output logic [bss_pkg::STEP_OUT_W-1:0]  m_div_step,
    output logic [bss_pkg::ERR_W-1:0]       m_rate_error
);

    bss_pkg::state_t                     state_reg, state_next;
    logic [bss_pkg::REF_W-1:0]           ref_clk_reg;
    logic [bss_pkg::BAUD_W-1:0]          baud_reg, baud_next;
    logic [bss_pkg::BM_W-1:0]            bm_reg, bm_next;
    logic [bss_pkg::SCALE_W-1:0]         scale_reg, scale_next;
    logic [bss_pkg::STEP_W-1:0]          step_reg, step_next;
    logic [bss_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic [bss_pkg::SCALE_W-1:0]         best_scale_reg, best_scale_next;
    logic [bss_pkg::STEP_W-1:0]          best_step_reg, best_step_next;
    logic [bss_pkg::ERR_W-1:0]           best_err_reg, best_err_next;
    logic                                m_valid_reg, m_valid_next;
    logic [bss_pkg::SCALE_OUT_W-1:0]     out_scale_reg, out_scale_next;
    logic [bss_pkg::STEP_OUT_W-1:0]      out_step_reg, out_step_next;
    logic [bss_pkg::ERR_W-1:0]           out_err_reg, out_err_next;

    bss_pkg::div_req_t                   div_req;
    bss_pkg::div_rsp_t                   div_rsp;

    logic [bss_pkg::SCALE1_W-1:0]        scale_plus1;
    logic [bss_pkg::PROD_W:0]            rate_sum;
    logic [bss_pkg::RATE_NUM_W-1:0]      rate_num;
    logic [bss_pkg::RATE_NUM_W-1:0]      rate;
    logic [bss_pkg::RATE_NUM_W-1:0]      baud_ext;
    logic [bss_pkg::RATE_NUM_W-1:0]      err;

    bss_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Rate numerator: clk*step plus half the divisor, then drop the 2^17 part
    always_comb begin
        scale_plus1 = bss_pkg::SCALE1_W'(scale_reg) + bss_pkg::SCALE1_W'(1);
        rate_sum    = {1'b0, prod_reg}
                    + ((bss_pkg::PROD_W+1)'(scale_plus1) << (bss_pkg::FRAC_SHIFT - 1));
        rate_num    = rate_sum[bss_pkg::PROD_W:bss_pkg::FRAC_SHIFT];
        rate        = div_rsp.quotient[bss_pkg::RATE_NUM_W-1:0];
        baud_ext    = bss_pkg::RATE_NUM_W'(baud_reg);
        err         = (rate >= baud_ext) ? (rate - baud_ext) : (baud_ext - rate);
    end

    // Search sequencer
    always_comb begin
        state_next      = state_reg;
        baud_next       = baud_reg;
        bm_next         = bm_reg;
        scale_next      = scale_reg;
        step_next       = step_reg;
        prod_next       = prod_reg;
        best_scale_next = best_scale_reg;
        best_step_next  = best_step_reg;
        best_err_next   = best_err_reg;
        out_scale_next  = out_scale_reg;
        out_step_next   = out_step_reg;
        out_err_next    = out_err_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        div_req.start    = 1'b0;
        div_req.dividend = {bm_reg, bss_pkg::FRAC_SHIFT'(0)};
        div_req.divisor  = ref_clk_reg;
        div_req.iters    = bss_pkg::CNT_W'(bss_pkg::NUM_W);

        unique case (state_reg)
            bss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    baud_next       = s_target_baud;
                    bm_next         = bss_pkg::BM_W'(s_target_baud);
                    scale_next      = '0;
                    best_scale_next = '0;
                    best_step_next  = '0;
                    best_err_next   = s_target_baud;
                    state_next      = (ref_clk_reg == '0) ? bss_pkg::ST_FINISH
                                                          : bss_pkg::ST_STEP_GO;
                end
            end
            bss_pkg::ST_STEP_GO: begin
                // step = baud*(s+1)*2^17 / clk
                div_req.start = 1'b1;
                state_next    = bss_pkg::ST_STEP_WAIT;
            end
            bss_pkg::ST_STEP_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient > bss_pkg::NUM_W'(bss_pkg::STEP_MAX)) begin
                        state_next = bss_pkg::ST_FINISH;
                    end else begin
                        step_next  = div_rsp.quotient[bss_pkg::STEP_W-1:0];
                        state_next = bss_pkg::ST_MUL;
                    end
                end
            end
            bss_pkg::ST_MUL: begin
                prod_next  = bss_pkg::PROD_W'(ref_clk_reg) * bss_pkg::PROD_W'(step_reg);
                state_next = bss_pkg::ST_RATE_GO;
            end
            bss_pkg::ST_RATE_GO: begin
                // rate = rate_num / (s+1), rate_num left-aligned in the dividend
                div_req.start    = 1'b1;
                div_req.dividend = {rate_num,
                                    (bss_pkg::NUM_W - bss_pkg::RATE_NUM_W)'(0)};
                div_req.divisor  = bss_pkg::REF_W'(scale_plus1);
                div_req.iters    = bss_pkg::CNT_W'(bss_pkg::RATE_NUM_W);
                state_next       = bss_pkg::ST_RATE_WAIT;
            end
            bss_pkg::ST_RATE_WAIT: begin
                if (div_rsp.done) begin
                    state_next = bss_pkg::ST_CMP;
                end
            end
            bss_pkg::ST_CMP: begin
                // keep a strictly better pair
                if (err < bss_pkg::RATE_NUM_W'(best_err_reg)) begin
                    best_err_next   = err[bss_pkg::ERR_W-1:0];
                    best_scale_next = scale_reg;
                    best_step_next  = step_reg;
                end
                if (scale_reg == bss_pkg::SCALE_W'(bss_pkg::SCALE_COUNT - 1)) begin
                    state_next = bss_pkg::ST_FINISH;
                end else begin
                    scale_next = scale_reg + bss_pkg::SCALE_W'(1);
                    bm_next    = bm_reg + bss_pkg::BM_W'(baud_reg);
                    state_next = bss_pkg::ST_STEP_GO;
                end
            end
            bss_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_scale_next = bss_pkg::SCALE_OUT_W'(best_scale_reg);
                    out_step_next  = bss_pkg::STEP_OUT_W'(best_step_reg);
                    out_err_next   = best_err_reg;
                    m_valid_next   = 1'b1;
                    state_next     = bss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bss_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bss_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            ref_clk_reg <= bss_pkg::REF_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                ref_clk_reg <= cfg_wdata;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        baud_reg       <= baud_next;
        bm_reg         <= bm_next;
        scale_reg      <= scale_next;
        step_reg       <= step_next;
        prod_reg       <= prod_next;
        best_scale_reg <= best_scale_next;
        best_step_reg  <= best_step_next;
        best_err_reg   <= best_err_next;
        out_scale_reg  <= out_scale_next;
        out_step_reg   <= out_step_next;
        out_err_reg    <= out_err_next;
    end

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == bss_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_div_scale  = out_scale_reg;
    assign m_div_step   = out_step_reg;
    assign m_rate_error = out_err_reg;

    // Checks
    `ASSERT_IMP(a_err_bound, aclk, aresetn, state_reg != bss_pkg::ST_IDLE,
                best_err_reg <= baud_reg)
    `ASSERT_IMP(a_best_scale_seen, aclk, aresetn, state_reg != bss_pkg::ST_IDLE,
                best_scale_reg <= scale_reg)
    `ASSERT_IMP(a_div_done_waited, aclk, aresetn, div_rsp.done,
                state_reg == bss_pkg::ST_STEP_WAIT || state_reg == bss_pkg::ST_RATE_WAIT)
    `ASSERT_NXT(a_start_waits, aclk, aresetn, div_req.start,
                state_reg == bss_pkg::ST_STEP_WAIT || state_reg == bss_pkg::ST_RATE_WAIT)

endmodule
